// ----- hdl/rref_pkg.sv -----
// ============================================================================
// rref_pkg: shared types, constants and GF(2^8) helpers
// Field arithmetic over polynomial 0x11D and sizing defaults for the decoder.
// ============================================================================
package rref_pkg;

   localparam int DEF_MAX_ROWS    = 8;
   localparam int DEF_MAX_PAYLOAD = 64;
   localparam logic [8:0] GF_POLY = 9'h11D;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [0:0] CSR_COEFF_COUNT = 1'b0;
   localparam logic [0:0] CSR_PAYLOAD_LEN = 1'b1;

   localparam logic KIND_ROW  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Multiply two field elements (eight shift-and-add steps on bytes).
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'd0;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         x = x[7] ? ((x << 1) ^ GF_POLY[7:0]) : (x << 1);
      end
      return acc;
   endfunction

endpackage

// ----- hdl/rref_gf_unit.sv -----
// ============================================================================
// rref_gf_unit: shared GF(2^8) multiply-accumulate unit
// Computes acc ^ (a * b) with a register on the result.
// ============================================================================
module rref_gf_unit
   import rref_pkg::*;
(
   input  logic       clock,
   input  logic [7:0] a,
   input  logic [7:0] b,
   input  logic [7:0] acc,
   output logic [7:0] y
);

   logic [7:0] y_ff;

   // Registered multiply-accumulate.
   always_ff @(posedge clock) begin
      y_ff <= acc ^ gf_mul(a, b);
   end

   assign y = y_ff;

endmodule

// ----- hdl/gf256_incremental_rref_decoder.sv -----
// ============================================================================
// gf256_incremental_rref_decoder: RLNC Gaussian elimination core over GF(2^8)
// Buffers an augmented row, inserts it and reduces the store to RREF with one
// shared multiply unit and a single-port byte memory.
// ============================================================================
// A push that does not complete a row and op 3 are handled in S_IDLE; busy stays low.
// A read steps through S_READ and S_READ_OUT, where the result strobe is registered.
// A completing push scans the coefficient bytes and copies the row buffer, then per pivot
// forms the inverse, scales the pivot row, swaps it into place if needed and eliminates.
// Clear and reset sweep the whole store one byte a cycle;
// busy is high meanwhile. Results are strobed on rsp_valid for one cycle, no stall.
module gf256_incremental_rref_decoder
   import rref_pkg::*;
#(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [6:0] csr_wdata,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [7:0] req_symbol,
   input  logic [2:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   output logic       rsp_kind,
   output logic [2:0] rsp_stored_row,
   output logic [3:0] rsp_rank,
   output logic       rsp_full_rank,
   output logic [7:0] rsp_read_data
);

   localparam int ROW_W = MAX_ROWS + MAX_PAYLOAD;
   localparam int DEPTH = MAX_ROWS * ROW_W;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(ROW_W + 1);
   localparam int BW    = (ROW_W > 1) ? $clog2(ROW_W) : 1;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_READ, S_READ_OUT,
      S_SCAN_RD, S_SCAN_CHK, S_INS,
      S_PIV_RD, S_PIV_CHK, S_INV_MUL, S_INV_SQ,
      S_SCL_RD, S_SCL_MUL, S_SCL_WR,
      S_SWP_RA, S_SWP_RB, S_SWP_WA, S_SWP_WB,
      S_ELF_RD, S_ELF_CHK, S_EL_RP, S_EL_RR, S_EL_MUL, S_EL_WR,
      S_DONE
   } state_type;

   state_type state_ff;

   // Store memory and row buffer.
   logic [7:0] mem [DEPTH];
   logic [7:0] rbuf [ROW_W];
   logic [7:0] mem_q;
   logic [AW-1:0] addr;
   logic          mem_we;
   logic [7:0]    mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= mem_wd;
      mem_q <= mem[addr];
   end

   logic       rb_we;
   logic [BW-1:0] rb_wa, rb_ra;
   logic [7:0] rb_q;
   always_ff @(posedge clock) begin
      if (rb_we) rbuf[rb_wa] <= req_symbol;
      rb_q <= rbuf[rb_ra];
   end

   // Configuration and effective sizes.
   logic [3:0] coeff_ff;
   logic [6:0] plen_ff;
   logic [CW-1:0] cnt_ff;
   logic [RCW-1:0] n_eff;
   logic [CW-1:0]  width_eff;
   logic [CW-1:0]  p_eff;

   always_comb begin
      if (coeff_ff == 4'd0) n_eff = RCW'(1);
      else if (32'(coeff_ff) > MAX_ROWS) n_eff = RCW'(MAX_ROWS);
      else n_eff = RCW'(coeff_ff);
      if (plen_ff == 7'd0) p_eff = CW'(1);
      else if (32'(plen_ff) > MAX_PAYLOAD) p_eff = CW'(MAX_PAYLOAD);
      else p_eff = CW'(plen_ff);
      width_eff = CW'(n_eff) + p_eff;
   end

   // Shared multiplier.
   logic [7:0] mul_a, mul_b, mul_c, mul_y;
   rref_gf_unit u_gf (.clock(clock), .a(mul_a), .b(mul_b), .acc(mul_c), .y(mul_y));

   // Sequencer registers.
   logic [AW-1:0]  clr_ff;
   logic [RCW-1:0] row_ff, tgt_ff, piv_ff, pr_ff, er_ff;
   logic [CW-1:0]  col_ff, pc_ff;
   logic [7:0]     inv_ff, base_ff, f_ff, t_ff;
   logic [2:0]     ex_ff;
   logic [7:0]     rdq_ff;

   function automatic logic [AW-1:0] ad(input logic [RCW-1:0] r, input logic [CW-1:0] c);
      return AW'(32'(r) * ROW_W + 32'(c));
   endfunction

   // Address, write and multiplier operand selection.
   always_comb begin
      addr   = '0;
      mem_we = 1'b0;
      mem_wd = 8'd0;
      rb_we  = 1'b0;
      rb_wa  = cnt_ff[BW-1:0];
      rb_ra  = col_ff[BW-1:0];
      mul_a  = 8'd0;
      mul_b  = 8'd0;
      mul_c  = 8'd0;
      case (state_ff)
         S_CLR: begin
            addr = clr_ff; mem_we = 1'b1;
         end
         S_IDLE: begin
            addr = AW'(32'(req_read_row) * ROW_W + 32'(req_read_col));
            rb_we = start && (req_op == OP_PUSH);
            if (cnt_ff >= width_eff) rb_wa = '0;
         end
         S_SCAN_RD: addr = ad(row_ff, col_ff);
         // The first cycle only primes the buffer read, so nothing is written then.
         S_INS: begin
            addr = ad(tgt_ff, col_ff - CW'(1)); mem_we = (col_ff != '0);
            mem_wd = (col_ff - CW'(1) < width_eff) ? rb_q : 8'd0;
         end
         S_PIV_RD, S_ELF_RD: addr = ad(S_PIV_RD == state_ff ? row_ff : er_ff, pc_ff);
         // The square from the previous step is taken straight from the unit.
         S_INV_MUL: begin mul_a = inv_ff; mul_b = (ex_ff != 3'd0) ? mul_y : base_ff; end
         S_INV_SQ:  begin mul_a = base_ff; mul_b = base_ff; end
         S_SCL_RD: addr = ad(pr_ff, col_ff);
         S_SCL_MUL: begin mul_a = mem_q; mul_b = inv_ff; end
         S_SCL_WR: begin addr = ad(pr_ff, col_ff); mem_we = 1'b1; mem_wd = mul_y; end
         S_SWP_RA: addr = ad(pr_ff, col_ff);
         S_SWP_RB: addr = ad(piv_ff, col_ff);
         S_SWP_WA: begin addr = ad(pr_ff, col_ff); mem_we = 1'b1; mem_wd = mem_q; end
         S_SWP_WB: begin addr = ad(piv_ff, col_ff); mem_we = 1'b1; mem_wd = t_ff; end
         S_EL_RP: addr = ad(piv_ff, col_ff);
         S_EL_RR: addr = ad(er_ff, col_ff);
         S_EL_MUL: begin mul_a = t_ff; mul_b = f_ff; mul_c = mem_q; end
         S_EL_WR: begin addr = ad(er_ff, col_ff); mem_we = 1'b1; mem_wd = mul_y; end
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         clr_ff    <= '0;
         cnt_ff    <= '0;
         coeff_ff  <= 4'd8;
         plen_ff   <= 7'd64;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_we) begin
            cnt_ff <= '0;
            if (csr_index == CSR_COEFF_COUNT) coeff_ff <= csr_wdata[3:0];
            else plen_ff <= csr_wdata;
         end
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (32'(clr_ff) == DEPTH - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               case (req_op)
                  OP_PUSH: begin
                     if (cnt_ff >= width_eff) cnt_ff <= CW'(1);
                     else cnt_ff <= cnt_ff + CW'(1);
                     if (cnt_ff + CW'(1) == width_eff ||
                         (cnt_ff >= width_eff && width_eff == CW'(1))) begin
                        cnt_ff <= '0;
                        row_ff <= '0; col_ff <= '0;
                        state_ff <= S_SCAN_RD;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_ff <= '0; clr_ff <= '0; state_ff <= S_CLR;
                  end
                  OP_READ: begin
                     rdq_ff <= (32'(req_read_row) < MAX_ROWS &&
                                32'(req_read_col) < ROW_W) ? 8'd1 : 8'd0;
                     state_ff <= S_READ;
                  end
                  default: ;
               endcase
            end
            // Capture the read byte before the address moves on.
            S_READ: begin
               rdq_ff <= rdq_ff[0] ? mem_q : 8'd0;
               state_ff <= S_READ_OUT;
            end
            S_READ_OUT: begin
               rsp_valid <= 1'b1; rsp_kind <= KIND_READ;
               rsp_stored_row <= 3'd0; rsp_rank <= 4'd0; rsp_full_rank <= 1'b0;
               rsp_read_data <= rdq_ff;
               state_ff <= S_IDLE;
            end
            // Find the first row whose coefficient part is zero, else take the last row.
            S_SCAN_RD: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (mem_q != 8'd0) begin
                  if (row_ff == n_eff - RCW'(1)) begin
                     tgt_ff <= row_ff; col_ff <= '0; state_ff <= S_INS;
                  end else begin
                     row_ff <= row_ff + RCW'(1); col_ff <= '0; state_ff <= S_SCAN_RD;
                  end
               end else if (col_ff == CW'(n_eff) - CW'(1)) begin
                  tgt_ff <= row_ff; col_ff <= '0; state_ff <= S_INS;
               end else begin
                  col_ff <= col_ff + CW'(1); state_ff <= S_SCAN_RD;
               end
            end
            // Copy the row buffer (the buffer read runs one column ahead of the write via col_ff).
            S_INS: begin
               if (col_ff == CW'(ROW_W)) begin
                  piv_ff <= '0; pc_ff <= '0; row_ff <= '0; state_ff <= S_PIV_RD;
               end else col_ff <= col_ff + CW'(1);
            end
            S_PIV_RD: state_ff <= S_PIV_CHK;
            S_PIV_CHK: begin
               if (mem_q != 8'd0) begin
                  pr_ff <= row_ff; base_ff <= mem_q; inv_ff <= 8'd1;
                  ex_ff <= '0; state_ff <= S_INV_MUL;
               end else if (row_ff == n_eff - RCW'(1)) begin
                  if (pc_ff == CW'(n_eff) - CW'(1)) state_ff <= S_DONE;
                  else begin
                     pc_ff <= pc_ff + CW'(1); row_ff <= piv_ff; state_ff <= S_PIV_RD;
                  end
               end else begin
                  row_ff <= row_ff + RCW'(1); state_ff <= S_PIV_RD;
               end
            end
            // a^254: bits 1..7 of the exponent are set, bit 0 clear.
            S_INV_MUL: begin
               if (ex_ff != 3'd0) base_ff <= mul_y;
               state_ff <= S_INV_SQ;
            end
            S_INV_SQ: begin
               if (ex_ff != 3'd0) inv_ff <= mul_y;
               state_ff <= S_INV_MUL;
               ex_ff <= ex_ff + 3'd1;
               if (ex_ff == 3'd7) begin
                  inv_ff <= mul_y; col_ff <= pc_ff; state_ff <= S_SCL_RD;
               end
            end
            S_SCL_RD: state_ff <= S_SCL_MUL;
            S_SCL_MUL: state_ff <= S_SCL_WR;
            S_SCL_WR: begin
               if (col_ff == width_eff - CW'(1)) begin
                  col_ff <= '0;
                  state_ff <= (pr_ff != piv_ff) ? S_SWP_RA : S_ELF_RD;
                  er_ff <= '0;
               end else begin
                  col_ff <= col_ff + CW'(1); state_ff <= S_SCL_RD;
               end
            end
            S_SWP_RA: state_ff <= S_SWP_RB;
            S_SWP_RB: begin t_ff <= mem_q; state_ff <= S_SWP_WA; end
            S_SWP_WA: state_ff <= S_SWP_WB;
            S_SWP_WB: begin
               if (col_ff == width_eff - CW'(1)) begin
                  er_ff <= '0; state_ff <= S_ELF_RD;
               end else begin
                  col_ff <= col_ff + CW'(1); state_ff <= S_SWP_RA;
               end
            end
            // Elimination: factor read, then per-column read/read/mac/write.
            S_ELF_RD: state_ff <= S_ELF_CHK;
            S_ELF_CHK: begin
               if (er_ff != piv_ff && mem_q != 8'd0) begin
                  f_ff <= mem_q; col_ff <= pc_ff; state_ff <= S_EL_RP;
               end else if (er_ff == n_eff - RCW'(1)) begin
                  piv_ff <= piv_ff + RCW'(1);
                  if (pc_ff == CW'(n_eff) - CW'(1)) state_ff <= S_DONE;
                  else begin
                     pc_ff <= pc_ff + CW'(1); row_ff <= piv_ff + RCW'(1);
                     state_ff <= (piv_ff + RCW'(1) == n_eff) ? S_DONE : S_PIV_RD;
                  end
               end else begin
                  er_ff <= er_ff + RCW'(1); state_ff <= S_ELF_RD;
               end
            end
            S_EL_RP: state_ff <= S_EL_RR;
            S_EL_RR: begin t_ff <= mem_q; state_ff <= S_EL_MUL; end
            S_EL_MUL: state_ff <= S_EL_WR;
            S_EL_WR: begin
               if (col_ff == width_eff - CW'(1)) begin
                  if (er_ff == n_eff - RCW'(1)) begin
                     piv_ff <= piv_ff + RCW'(1);
                     if (pc_ff == CW'(n_eff) - CW'(1)) state_ff <= S_DONE;
                     else begin
                        pc_ff <= pc_ff + CW'(1); row_ff <= piv_ff + RCW'(1);
                        state_ff <= (piv_ff + RCW'(1) == n_eff) ? S_DONE : S_PIV_RD;
                     end
                  end else begin
                     er_ff <= er_ff + RCW'(1); state_ff <= S_ELF_RD;
                  end
               end else begin
                  col_ff <= col_ff + CW'(1); state_ff <= S_EL_RP;
               end
            end
            S_DONE: begin
               rsp_valid <= 1'b1; rsp_kind <= KIND_ROW;
               rsp_stored_row <= 3'(tgt_ff);
               rsp_rank <= 4'(piv_ff);
               rsp_full_rank <= (piv_ff == n_eff);
               rsp_read_data <= 8'd0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
